// ===== src/row_softmax_macros.svh =====
// Assertion macros for the row softmax block
`ifndef ROW_SOFTMAX_MACROS_SVH
`define ROW_SOFTMAX_MACROS_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RSM_ASSERT(label, prop, msg)
`define RSM_NEVER(label, cond, msg)
`endif
`endif

// ===== src/rsm_pkg.sv =====
// Shared types and constants of the row softmax block
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;
    localparam int RSM_MAX_COLS   = 64;
    localparam int RSM_SUM_W      = 23;
    localparam int RSM_EXP_W      = 17;
    localparam int RSM_NUM_W      = 33;
    localparam logic [15:0] RSM_FLUSH_LIMIT = 16'd2839;
    localparam logic [3:0]  RSM_EXP_LAST    = 4'd13;
    localparam logic [15:0] RSM_Q88_MIN     = 16'h8000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM_RD,
        ST_SUM_EXP,
        ST_SUM_WAIT,
        ST_EMIT_RD,
        ST_EMIT_EXP,
        ST_EMIT_WAIT,
        ST_OUT
    } rsm_state_t;
endpackage
`default_nettype wire

// ===== src/rsm_ram.sv =====
// Generic single-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/rsm_exp.sv =====
// Iterative exp(-t) unit on one shared 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none
module rsm_exp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [15:0]                   span,
    output logic                               done,
    output logic [rsm_pkg::RSM_EXP_W-1:0]      value
);
    import rsm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] y2_reg, y2_next;
    logic [31:0] y3_reg, y3_next;
    logic [31:0] e_reg, e_next;
    logic [RSM_EXP_W-1:0] val_reg, val_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [32:0] e_init;
    logic [32:0] rnd;

    // pick multiplier operands by step
    always_comb
    begin
        case (step_reg)
            4'd0:    begin mul_a = y_reg;  mul_b = y_reg;  end
            4'd1:    begin mul_a = y2_reg; mul_b = y_reg;  end
            4'd2:    begin mul_a = y3_reg; mul_b = 32'd683; end
            default: begin mul_a = e_reg;  mul_b = e_reg;  end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // series value: 1 - y + y^2/2 - y^3/6, division by six via reciprocal
    assign e_init = 33'h1_0000_0000 - 33'(y_reg) + 33'(y2_reg >> 1) - 33'(prod[43:12]);
    assign rnd    = 33'(prod[63:32]) + 33'd32768;

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        y_next    = y_reg;
        y2_next   = y2_reg;
        y3_next   = y3_reg;
        e_next    = e_reg;
        val_next  = val_reg;
        if (start)
        begin
            step_next = 4'd0;
            y_next    = {3'b0, span, 13'b0};
            if (span == 16'd0)
            begin
                val_next  = RSM_EXP_W'(65536);
                done_next = 1'b1;
            end
            else if (span > RSM_FLUSH_LIMIT)
            begin
                val_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 4'd1;
            case (step_reg)
                4'd0:    y2_next = prod[63:32];
                4'd1:    y3_next = prod[63:32];
                4'd2:    e_next  = e_init[31:0];
                default: e_next  = prod[63:32];
            endcase
            if (step_reg == RSM_EXP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                val_next  = rnd[32:16];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        y2_reg  <= y2_next;
        y3_reg  <= y3_next;
        e_reg   <= e_next;
        val_reg <= val_next;
    end

    assign done  = done_reg;
    assign value = val_reg;
endmodule
`default_nettype wire

// ===== src/rsm_div.sv =====
// Bit-serial restoring divider, one quotient bit a cycle, saturating
`timescale 1ns / 1ps
`default_nettype none
module rsm_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [rsm_pkg::RSM_EXP_W-1:0] ex,
    input  wire logic [rsm_pkg::RSM_SUM_W-1:0] sum,
    output logic                              done,
    output logic [15:0]                       quot
);
    import rsm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [RSM_NUM_W-1:0] num_reg, num_next;
    logic [RSM_NUM_W-1:0] q_reg, q_next;
    logic [RSM_SUM_W:0]   rem_reg, rem_next;
    logic [RSM_SUM_W-1:0] d_reg, d_next;
    logic [RSM_SUM_W:0]   trial;

    assign trial = {rem_reg[RSM_SUM_W-1:0], num_reg[RSM_NUM_W-1]};

    // shift one numerator bit in, subtract where it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {ex, 16'b0} + RSM_NUM_W'(sum >> 1);
            q_next    = '0;
            rem_next  = '0;
            d_next    = sum;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            cnt_next = cnt_reg + 6'd1;
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[RSM_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[RSM_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == 6'(RSM_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    // saturate to the top of Q0.16
    assign quot = (q_reg[RSM_NUM_W-1:16] != '0) ? 16'hFFFF : q_reg[15:0];
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== src/row_softmax.sv =====
// Row softmax top level: row buffer, sequencer, exp unit and divider
// Scores stream in one word per cycle while the row is loaded; a word with tlast (or the
// MAX_COLS-th word) closes the row. The block then drops s_tready and makes two passes over
// the buffered row: a summing pass (RAM read, exp start and the 14-step exp unit on a
// single shared multiplier, whose steps are skipped when the distance to the maximum is zero
// or flushed) and an emit pass (RAM read, exp again, the 33-step bit-serial divider and the
// output hand-off, which waits on m_tready). Probabilities are unsigned Q0.16, 1.0
// saturating to 65535; tlast marks the last one of the row.
`timescale 1ns / 1ps
`default_nettype none
`include "row_softmax_macros.svh"
module row_softmax #(
    parameter int MAX_COLS = rsm_pkg::RSM_MAX_COLS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] score
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] probability
    output logic             m_tlast
);
    import rsm_pkg::*;

    localparam int IW = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);

    rsm_state_t           state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [15:0]          max_reg, max_next;
    logic [RSM_SUM_W-1:0] sum_reg, sum_next;
    logic [15:0]          prob_reg, prob_next;
    logic                 last_reg, last_next;
    logic                 s_acc, m_acc, row_close, idx_last;
    logic                 exp_start, exp_done, div_start, div_done;
    logic [RSM_EXP_W-1:0] exp_val;
    logic [15:0]          quot;
    logic [15:0]          rd_score;
    logic [16:0]          diff;
    logic [15:0]          acc_max;

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign row_close = s_tlast || (fill_reg + CW'(1) == CW'(MAX_COLS));
    assign idx_last  = (CW'(idx_reg) + CW'(1) == fill_reg);
    assign acc_max   = ($signed(s_tdata) > $signed(max_reg)) ? s_tdata : max_reg;
    assign diff      = {max_reg[15], max_reg} - {rd_score[15], rd_score};

    rsm_ram #(.WIDTH(16), .DEPTH(MAX_COLS)) u_row_ram (
        .clk   (clk),
        .we    (s_acc),
        .waddr (fill_reg[IW-1:0]),
        .wdata (s_tdata),
        .raddr (idx_reg),
        .rdata (rd_score)
    );

    rsm_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .span  (diff[15:0]),
        .done  (exp_done),
        .value (exp_val)
    );

    rsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .ex    (exp_val),
        .sum   (sum_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_acc && row_close) state_next = ST_SUM_RD;
            ST_SUM_RD:    state_next = ST_SUM_EXP;
            ST_SUM_EXP:   state_next = ST_SUM_WAIT;
            ST_SUM_WAIT:  if (exp_done) state_next = idx_last ? ST_EMIT_RD : ST_SUM_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_EXP;
            ST_EMIT_EXP:  state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:       if (m_acc) state_next = last_reg ? ST_LOAD : ST_EMIT_RD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        exp_start = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_LOAD:      s_tready  = 1'b1;
            ST_SUM_EXP:   exp_start = 1'b1;
            ST_EMIT_EXP:  exp_start = 1'b1;
            ST_EMIT_WAIT: div_start = exp_done;
            ST_OUT:       m_tvalid  = 1'b1;
            default:      ;
        endcase
    end

    // row bookkeeping
    always_comb
    begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        max_next  = max_reg;
        sum_next  = sum_reg;
        prob_next = prob_reg;
        last_next = last_reg;
        if (s_acc)
        begin
            fill_next = fill_reg + CW'(1);
            max_next  = acc_max;
            idx_next  = '0;
            sum_next  = '0;
        end
        if (state_reg == ST_SUM_WAIT && exp_done)
        begin
            sum_next = sum_reg + RSM_SUM_W'(exp_val);
            idx_next = idx_last ? '0 : idx_reg + IW'(1);
        end
        if (state_reg == ST_EMIT_WAIT && div_done)
        begin
            prob_next = quot;
            last_next = idx_last;
        end
        if (m_acc)
        begin
            idx_next = idx_reg + IW'(1);
            if (last_reg)
            begin
                fill_next = '0;
                max_next  = RSM_Q88_MIN;
                sum_next  = '0;
                idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            idx_reg   <= '0;
            max_reg   <= RSM_Q88_MIN;
            sum_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg <= prob_next;
    end

    assign m_tdata = prob_reg;
    assign m_tlast = last_reg;

    `RSM_NEVER(a_ready_vs_valid, s_tready && m_tvalid, "input and output open together")
    `RSM_NEVER(a_fill_bound, fill_reg > CW'(MAX_COLS), "row buffer overfilled")
    `RSM_ASSERT(a_row_cleared, m_acc && m_tlast |=> fill_reg == '0, "row not cleared")
    `RSM_ASSERT(a_close_leaves_load, s_acc && row_close |=> !s_tready, "row end not taken")
endmodule
`default_nettype wire

// ===== bench/row_softmax_tb.sv =====
// Self-checking testbench for the row softmax block
`timescale 1ns / 1ps
module row_softmax_tb;
    import rsm_pkg::*;

    localparam int  COLS        = RSM_MAX_COLS;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 5000;
    localparam int  HOLD_START  = 2000;
    localparam int  HOLD_LEN    = 3000;

    typedef struct packed {
        logic [15:0] score;
        logic        row_end;
    } score_word_t;

    typedef struct packed {
        logic [15:0] prob;
        logic        last;
    } prob_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    score_word_t pending_scores[$];
    prob_word_t  expected_probs[$];
    int          errors;
    int          cycle;
    int          words_sent;
    int          words_taken;
    int          total_words;

    // predictor state
    logic [15:0] row_buf[COLS];
    logic signed [15:0] row_peak;
    int          row_fill;

    row_softmax dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Q1.16 exponential of minus a Q8.8 distance
    function automatic logic [16:0] neg_exp(input logic [15:0] span);
        logic [63:0] y, y2, y3, e;
        if (span == 16'd0)
            return 17'd65536;
        if (span > RSM_FLUSH_LIMIT)
            return 17'd0;
        y  = 64'(span) << 13;
        y2 = (y * y) >> 32;
        y3 = (y2 * y) >> 32;
        e  = (64'd1 << 32) - y + (y2 >> 1) - y3 / 64'd6;
        for (int k = 0; k < 11; k++)
            e = (e * e) >> 32;
        return 17'((e + 64'd32768) >> 16);
    endfunction

    // Buffer one score and, on row close, queue the row's probabilities
    task automatic predict_score(input score_word_t w);
        logic [22:0] total;
        logic [63:0] p;
        logic [16:0] ex;
        prob_word_t  r;
        if (row_fill < COLS)
        begin
            row_buf[row_fill] = w.score;
            row_fill++;
        end
        if ($signed(w.score) > row_peak)
            row_peak = w.score;
        if (!w.row_end && row_fill < COLS)
            return;
        total = '0;
        for (int i = 0; i < row_fill; i++)
            total += 23'(neg_exp(16'(row_peak - $signed(row_buf[i]))));
        for (int i = 0; i < row_fill; i++)
        begin
            ex = neg_exp(16'(row_peak - $signed(row_buf[i])));
            p  = ((64'(ex) << 16) + 64'(total >> 1)) / 64'(total);
            r.prob = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            r.last = (i + 1 == row_fill);
            expected_probs = {expected_probs, r};
        end
        row_peak = RSM_Q88_MIN;
        row_fill = 0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
        errors++;
    endtask

    task automatic add_row(input int len, input logic close, input int spread);
        score_word_t w;
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (spread == 0)
                w.score = 16'($urandom);
            else
                w.score = base + 16'($urandom_range(0, spread));
            w.row_end = close && (i == len - 1);
            pending_scores = {pending_scores, w};
        end
    endtask

    task automatic add_word(input logic [15:0] s, input logic e);
        score_word_t w;
        w.score   = s;
        w.row_end = e;
        pending_scores = {pending_scores, w};
    endtask

    // Monitor: predict on accepted scores, check accepted probabilities
    always @(posedge clk)
    begin
        prob_word_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_score('{score: s_tdata, row_end: s_tlast});
                words_taken <= words_taken + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_probs.size() == 0)
                    report_mismatch("unexpected probability", m_tdata, -1);
                else
                begin
                    want = expected_probs.pop_front();
                    if (m_tdata !== want.prob)
                        report_mismatch("probability", m_tdata, want.prob);
                    if (m_tlast !== want.last)
                        report_mismatch("last flag", m_tlast, want.last);
                end
            end
        end
    end

    // Driver: offer pending scores, idling at random outside the steady window
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (words_taken > words_sent)
            begin
                void'(pending_scores.pop_front());
                words_sent <= words_sent + 1;
            end
            if (s_tvalid && !(words_taken > words_sent))
                ; // hold the offered word until taken
            else if (pending_scores.size() == 0)
                s_tvalid <= 1'b0;
            else if ((words_sent < 60 || words_sent > 100)
                     && $urandom_range(0, 99) < 24)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_scores[0].score;
                s_tlast  <= pending_scores[0].row_end;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, a stretch with none
    always @(negedge clk)
    begin
        if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN)
            m_tready <= 1'b0;
        else if (cycle >= 6000 && cycle < 10000)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 24);
    end

    // Cycle count and timeout
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("row_softmax_tb: errors");
            $finish;
        end
    end

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        rst_n       = 1'b0;
        errors      = 0;
        cycle       = 0;
        words_sent  = 0;
        words_taken = 0;
        row_peak    = RSM_Q88_MIN;
        row_fill    = 0;

        // directed: single-element rows at the extremes and at zero
        add_word(16'h7FFF, 1'b1);
        add_word(16'h8000, 1'b1);
        add_word(16'h0000, 1'b1);
        // extremes in one row: the small one flushes to zero
        add_word(16'h8000, 1'b0);
        add_word(16'h7FFF, 1'b1);
        // equal scores, and distances around the flush limit
        add_word(16'h0100, 1'b0);
        add_word(16'h0100, 1'b0);
        add_word(16'h0100, 1'b1);
        add_word(16'h0000, 1'b0);
        add_word(16'(-2839), 1'b0);
        add_word(16'(-2840), 1'b0);
        add_word(16'hFFFF, 1'b1);
        // full row with no end flag closes itself, the next starts afresh
        add_row(COLS, 1'b0, 600);
        add_word(16'h1234, 1'b1);

        // random: mostly short rows of nearby scores, some wide and overlong
        while (pending_scores.size() < 116)
        begin
            case ($urandom_range(0, 9))
                0:       add_row($urandom_range(1, 8), 1'b1, 0);
                1:       add_row($urandom_range(1, 4), 1'b0, 1500);
                2:       add_row(($urandom_range(0, 5) == 0) ? COLS + 3 : 12, 1'b1, 3000);
                default: add_row($urandom_range(1, 8), 1'b1, $urandom_range(1, 2000));
            endcase
        end
        add_word(16'($urandom), 1'b1);
        total_words = pending_scores.size();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        wait (words_sent == total_words);
        wait (expected_probs.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("row_softmax_tb: clean");
        else
            $display("row_softmax_tb: errors");
        $finish;
    end
endmodule
